### hdl/assert_macros.svh
// Assertion helpers shared by the filter modules.
// Both macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### hdl/fnf_pkg.sv
package fnf_pkg;

	localparam int PIX_W       = 32;
	localparam int POS_W       = 10;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_DIM_W   = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int N_RES       = 3;
	localparam int N_CAND      = 4;
	localparam int ENT_W       = 2 * PIX_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

	localparam logic [CFG_DIM_W-1:0] DIM_RESET = 11'd4;

	typedef logic signed [PIX_W-1:0] pix_t;

	localparam pix_t NO_NBR = 32'sh8000_0000;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	// One line-store entry: the previous row and the row before it, same column.
	typedef struct packed {
		pix_t up1;
		pix_t up2;
	} ent_t;

	typedef pix_t [N_CAND-1:0] cand_t;
	typedef cand_t [N_RES-1:0] cand_set_t;

	typedef struct packed {
		logic [N_RES-1:0] mask;
		pos_t [N_RES-1:0] pos;
	} tag_t;

	function automatic pix_t smax(pix_t a, pix_t b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

	// Last valid index of a dimension: zero acts as one, oversized acts as the maximum.
	function automatic int unsigned dim_last(logic [CFG_DIM_W-1:0] v, int unsigned maxv);
		int unsigned d;
		d = 32'(v);
		if (d == 0) begin
			d = 1;
		end else if (d > maxv) begin
			d = maxv;
		end
		return d - 1;
	endfunction

endpackage

### hdl/four_neighbour_max_filter.sv
// Four-neighbour maximum filter. Pixels arrive in raster order, one word per cycle at most; for
// each position the block returns the largest in-frame up/down/left/right neighbour (the most
// negative value when there is none) together with its row and column, and tlast marks the
// final result of the frame. A result for row r-1 leaves with the pixel of row r below it, and
// last-row results leave as soon as their right neighbour is in. The block takes one pixel per
// cycle while the result pipeline has room. In the last row of a frame with two or more rows,
// every pixel after the first releases two results and the final pixel three, so there the
// single output word per cycle holds input back. Results pass through the registered stages s1,
// s2 and s3, and further results of the same pixel follow one per cycle while m_tready is high.
// The two previous rows live in one 64-bit RAM of 2**CW entries (MAX_COLS rounded up to a power of
// two) that is read one column ahead of the incoming pixel and written at its column; it needs no
// clearing after reset. Writing frame_rows or frame_cols restarts the frame at row 0, column 0.
`include "assert_macros.svh"

module four_neighbour_max_filter #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pixel_value
	input  logic [fnf_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_row, out_col, neighbour_max, 4 zero bits
	output logic [fnf_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_wr_en,
	input  logic [fnf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fnf_pkg::CFG_DIM_W-1:0]       cfg_data
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [RW-1:0] row_q, rows_last_q, row_nx, rowm1;
	logic [CW-1:0] col_q, cols_last_q, col_nx, col_d, raddr, colm1;
	logic          fwd_q;
	fnf_pkg::ent_t fwd_data_q, e0_q, col0_q, eff_rd, wdata;
	fnf_pkg::pix_t um1_q, p1_q, p2_q, pix;
	logic [fnf_pkg::ENT_W-1:0] ram_rdata;

	logic acc, cfg_rows, cfg_cols, cfg_hit, col_end, row_end;
	logic r_ge1, r_ge2, c_ge1, c_ge2;
	logic [RW+9:0] row_ext, rowm1_ext;
	logic [CW+9:0] col_ext, colm1_ext;
	logic pipe_ready;
	fnf_pkg::tag_t tag;
	fnf_pkg::cand_set_t cand;

	assign pix      = fnf_pkg::pix_t'(s_tdata);
	assign acc      = s_tvalid && s_tready;
	assign s_tready = pipe_ready;
	assign cfg_rows = cfg_wr_en && (cfg_index == fnf_pkg::REG_FRAME_ROWS);
	assign cfg_cols = cfg_wr_en && (cfg_index == fnf_pkg::REG_FRAME_COLS);
	assign cfg_hit  = cfg_rows || cfg_cols;

	assign col_end = (col_q == cols_last_q);
	assign row_end = (row_q == rows_last_q);
	assign col_nx  = col_end ? '0 : col_q + CW'(1);
	assign row_nx  = col_end ? (row_end ? '0 : row_q + RW'(1)) : row_q;
	assign col_d   = cfg_hit ? '0 : (acc ? col_nx : col_q);
	assign raddr   = col_d + CW'(1);

	assign eff_rd = fwd_q ? fwd_data_q : fnf_pkg::ent_t'(ram_rdata);
	assign wdata  = '{up1: pix, up2: e0_q.up1};

	fnf_ram #(
		.WIDTH(fnf_pkg::ENT_W),
		.DEPTH(2 ** CW)
	) u_line_ram (
		.clk  (clk),
		.we   (acc),
		.waddr(col_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			rows_last_q <= RW'(fnf_pkg::dim_last(fnf_pkg::DIM_RESET, MAX_ROWS));
			cols_last_q <= CW'(fnf_pkg::dim_last(fnf_pkg::DIM_RESET, MAX_COLS));
			fwd_q       <= 1'b0;
		end else begin
			if (cfg_hit) begin
				row_q <= '0;
				col_q <= '0;
			end else if (acc) begin
				row_q <= row_nx;
				col_q <= col_nx;
			end
			if (cfg_rows) begin
				rows_last_q <= RW'(fnf_pkg::dim_last(cfg_data, MAX_ROWS));
			end
			if (cfg_cols) begin
				cols_last_q <= CW'(fnf_pkg::dim_last(cfg_data, MAX_COLS));
			end
			fwd_q <= acc && (col_q == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wdata;
		if (acc) begin
			if (col_q == '0) begin
				col0_q <= wdata;
			end
			if (col_nx == '0) begin
				e0_q <= (col_q == '0) ? wdata : col0_q;
			end else begin
				e0_q <= eff_rd;
			end
			um1_q <= e0_q.up1;
			p1_q  <= pix;
			p2_q  <= p1_q;
		end
	end

	assign r_ge1 = (row_q != '0);
	assign r_ge2 = (row_q > RW'(1));
	assign c_ge1 = (col_q != '0);
	assign c_ge2 = (col_q > CW'(1));
	assign rowm1 = row_q - RW'(1);
	assign colm1 = col_q - CW'(1);
	assign row_ext   = {10'b0, row_q};
	assign rowm1_ext = {10'b0, rowm1};
	assign col_ext   = {10'b0, col_q};
	assign colm1_ext = {10'b0, colm1};

	always_comb begin
		tag.mask[0] = r_ge1;
		tag.mask[1] = row_end && c_ge1;
		tag.mask[2] = row_end && col_end;

		tag.pos[0].row = rowm1_ext[9:0];
		tag.pos[0].col = col_ext[9:0];
		tag.pos[1].row = row_ext[9:0];
		tag.pos[1].col = colm1_ext[9:0];
		tag.pos[2].row = row_ext[9:0];
		tag.pos[2].col = col_ext[9:0];

		cand[0][0] = r_ge2 ? e0_q.up2 : fnf_pkg::NO_NBR;
		cand[0][1] = pix;
		cand[0][2] = col_end ? fnf_pkg::NO_NBR : eff_rd.up1;
		cand[0][3] = c_ge1 ? um1_q : fnf_pkg::NO_NBR;

		cand[1][0] = r_ge1 ? um1_q : fnf_pkg::NO_NBR;
		cand[1][1] = pix;
		cand[1][2] = c_ge2 ? p2_q : fnf_pkg::NO_NBR;
		cand[1][3] = fnf_pkg::NO_NBR;

		cand[2][0] = r_ge1 ? e0_q.up1 : fnf_pkg::NO_NBR;
		cand[2][1] = c_ge1 ? p1_q : fnf_pkg::NO_NBR;
		cand[2][2] = fnf_pkg::NO_NBR;
		cand[2][3] = fnf_pkg::NO_NBR;
	end

	fnf_max_pipe u_max_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(acc),
		.in_ready(pipe_ready),
		.in_tag  (tag),
		.in_cand (cand),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	`ASSERT_NEVER(a_col_range, col_q > cols_last_q, "column counter beyond frame width")
	`ASSERT_NEVER(a_row_range, row_q > rows_last_q, "row counter beyond frame height")
	`ASSERT_CLK(a_fwd_src, fwd_q |-> $past(acc), "forwarding without a write")

endmodule

### hdl/fnf_ram.sv
module fnf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/fnf_max_pipe.sv
`include "assert_macros.svh"

module fnf_max_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  fnf_pkg::tag_t                     in_tag,
	input  fnf_pkg::cand_set_t                in_cand,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fnf_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);

	logic [fnf_pkg::N_RES-1:0] s1_mask, s2_mask, s3_mask;
	fnf_pkg::pos_t [fnf_pkg::N_RES-1:0] s1_pos, s2_pos, s3_pos;
	fnf_pkg::cand_set_t s1_cand;
	fnf_pkg::pix_t [fnf_pkg::N_RES-1:0][1:0] s2_pair;
	fnf_pkg::pix_t [fnf_pkg::N_RES-1:0] s3_max;

	logic ld1, ld2, ld3, pop;
	logic [1:0] sel;
	logic [fnf_pkg::N_RES-1:0] s3_rest;

	assign pop     = m_tvalid && m_tready;
	assign s3_rest = s3_mask & (s3_mask - 3'd1);
	assign ld3     = (s3_mask == '0) || (pop && (s3_rest == '0));
	assign ld2     = (s2_mask == '0) || ld3;
	assign ld1     = (s1_mask == '0) || ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_mask <= '0;
			s2_mask <= '0;
			s3_mask <= '0;
		end else begin
			if (ld1) begin
				s1_mask <= in_valid ? in_tag.mask : '0;
			end
			if (ld2) begin
				s2_mask <= s1_mask;
			end
			if (ld3) begin
				s3_mask <= s2_mask;
			end else if (pop) begin
				s3_mask <= s3_rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			s1_pos  <= in_tag.pos;
			s1_cand <= in_cand;
		end
		if (ld2) begin
			s2_pos <= s1_pos;
			for (int k = 0; k < fnf_pkg::N_RES; k++) begin
				s2_pair[k][0] <= fnf_pkg::smax(s1_cand[k][0], s1_cand[k][1]);
				s2_pair[k][1] <= fnf_pkg::smax(s1_cand[k][2], s1_cand[k][3]);
			end
		end
		if (ld3) begin
			s3_pos <= s2_pos;
			for (int k = 0; k < fnf_pkg::N_RES; k++) begin
				s3_max[k] <= fnf_pkg::smax(s2_pair[k][0], s2_pair[k][1]);
			end
		end
	end

	always_comb begin
		if (s3_mask[0]) begin
			sel = 2'd0;
		end else if (s3_mask[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign m_tvalid = (s3_mask != '0);
	assign m_tdata  = {4'b0000, s3_max[sel], s3_pos[sel].col, s3_pos[sel].row};
	assign m_tlast  = m_tvalid && (sel == 2'd2);

	`ASSERT_NEVER(a_last_is_final, m_tlast && (s3_mask[1:0] != 2'b00), "frame end ahead of results")
	`ASSERT_CLK(a_no_new_bits, !ld3 |=> ((s3_mask & ~$past(s3_mask)) == 3'b000), "result appeared")
	`ASSERT_CLK(a_load_shows, (ld3 && (s2_mask != 3'b000)) |=> m_tvalid, "loaded result lost")

endmodule
